FILE: hw/rtl/pfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer refresh package
// Shared types, codes, constants and a helper function of the block.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 128;
  localparam int unsigned PAGES_DEFAULT   = 8;

  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO_MASK = 8'h0F;
  localparam logic [7:0] CMD_COL_HI_BASE = 8'h10;
  localparam logic [7:0] PIXEL_BIT_TOP   = 8'h80;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_CMD_PAGE   = 2'd0,
    PH_CMD_COL_LO = 2'd1,
    PH_CMD_COL_HI = 2'd2,
    PH_DATA       = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_TICK_RD,
    ST_TICK_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_we;
    logic pix_we;
    logic rd_seq;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pix_hit;
    logic tick_go;
    logic out_full;
  } ctrl_status_t;

  function automatic logic [2:0] lowest_page(input logic [7:0] mask);
    logic [2:0] page;
    page = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i]) begin
        page = 3'(i);
      end
    end
    return page;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pfr_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer refresh input channel
// Valid/ready channel that carries one operation beat.
// ----------------------------------------------------------------------------
interface pfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] page_select;
  logic [6:0] first_column;
  logic [6:0] last_column;

  modport source (
    output valid, operation, pixel_x, pixel_y, page_select, first_column, last_column,
    input  ready
  );

  modport sink (
    input  valid, operation, pixel_x, pixel_y, page_select, first_column, last_column,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/pfr_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer refresh output channel
// Valid/ready channel that carries one panel byte beat.
// ----------------------------------------------------------------------------
interface pfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       final_byte;

  modport source (
    output valid, out_byte, is_data, final_byte,
    input  ready
  );

  modport sink (
    input  valid, out_byte, is_data, final_byte,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/pfr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer refresh RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pfr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer refresh controller
// Sequences the clearing pass, pixel read-modify-write and byte emission.
// ----------------------------------------------------------------------------
module pfr_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pfr_pkg::ctrl_status_t status_i,
  output pfr_pkg::ctrl_cmd_t         cmd_o
);

  pfr_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfr_pkg::ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = pfr_pkg::ST_IDLE;
        end
      end
      pfr_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.pix_hit) begin
          state_d = pfr_pkg::ST_PIX_WR;
        end else if (in_valid_i && status_i.tick_go) begin
          state_d = pfr_pkg::ST_TICK_RD;
        end
      end
      pfr_pkg::ST_PIX_WR: begin
        state_d = pfr_pkg::ST_IDLE;
      end
      pfr_pkg::ST_TICK_RD: begin
        if (!status_i.out_full) begin
          state_d = pfr_pkg::ST_TICK_OUT;
        end
      end
      pfr_pkg::ST_TICK_OUT: begin
        state_d = pfr_pkg::ST_IDLE;
      end
      default: begin
        state_d = pfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pfr_pkg::ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
      end
      pfr_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      pfr_pkg::ST_PIX_WR: begin
        cmd_o.pix_we = 1'b1;
      end
      pfr_pkg::ST_TICK_RD: begin
        cmd_o.rd_seq = 1'b1;
      end
      pfr_pkg::ST_TICK_OUT: begin
        cmd_o.rd_seq = 1'b1;
        cmd_o.emit   = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pfr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer refresh datapath
// Frame store, pixel update, refresh sequencer registers and output register.
// ----------------------------------------------------------------------------
module pfr_datapath #(
  parameter int unsigned COLUMNS = pfr_pkg::COLUMNS_DEFAULT,
  parameter int unsigned PAGES   = pfr_pkg::PAGES_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pfr_pkg::ctrl_cmd_t cmd_i,
  output pfr_pkg::ctrl_status_t   status_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [7:0]         pixel_x_i,
  input  wire logic [7:0]         pixel_y_i,
  input  wire logic [7:0]         page_select_i,
  input  wire logic [6:0]         first_column_i,
  input  wire logic [6:0]         last_column_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  output logic                    is_data_o,
  output logic                    final_byte_o
);

  localparam int unsigned DEPTH     = COLUMNS * PAGES;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned EW        = AW + 8;
  localparam logic [7:0]  PAGE_MASK = 8'((9'd1 << PAGES) - 9'd1);
  localparam logic [2:0]  LAST_PAGE = 3'(PAGES - 1);
  localparam logic [8:0]  COL_LIMIT = 9'(COLUMNS);
  localparam logic [7:0]  ROW_LIMIT = 8'(8 * PAGES);

  pfr_pkg::op_e op;
  logic         x_ok;
  logic         y_ok;
  logic [2:0]   pix_page;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] seq_addr;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          ram_we;

  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] pix_addr_q;
  logic [7:0]    pix_bit_q;
  logic          pix_set_q;

  logic [7:0]        pend_q, pend_d;
  logic [2:0]        cur_q, cur_d;
  pfr_pkg::phase_e   phase_q, phase_d;
  logic [6:0]        col_q, col_d;
  logic [6:0]        wfirst_q, wfirst_d;
  logic [6:0]        wlast_q, wlast_d;
  logic              active_q, active_d;
  logic [7:0]        pend_clr;
  logic              col_ok;

  logic [7:0] emit_byte;
  logic       emit_data;
  logic       emit_last;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       is_data_q;
  logic       final_byte_q;

  assign op       = pfr_pkg::op_e'(operation_i);
  assign x_ok     = {1'b0, pixel_x_i} < COL_LIMIT;
  assign y_ok     = pixel_y_i < ROW_LIMIT;
  assign pix_page = LAST_PAGE - pixel_y_i[5:3];
  assign pix_addr = AW'(EW'(pixel_x_i) * EW'(PAGES) + EW'(pix_page));
  assign seq_addr = AW'(EW'(col_q) * EW'(PAGES) + EW'(cur_q));
  assign col_ok   = {2'b00, col_q} < COL_LIMIT;

  assign status_o.clr_last = clr_addr_q == AW'(DEPTH - 1);
  assign status_o.pix_hit  = (op inside {pfr_pkg::OP_SET, pfr_pkg::OP_CLEAR}) && x_ok && y_ok;
  assign status_o.tick_go  = (op == pfr_pkg::OP_TICK) && active_q;
  assign status_o.out_full = out_valid_q;

  assign ram_we    = cmd_i.clr_we || cmd_i.pix_we;
  assign ram_waddr = cmd_i.clr_we ? clr_addr_q : pix_addr_q;
  assign ram_raddr = cmd_i.rd_seq ? seq_addr : pix_addr;

  always_comb begin
    if (cmd_i.clr_we) begin
      ram_wdata = pfr_pkg::BYTE_ZERO;
    end else if (pix_set_q) begin
      ram_wdata = ram_rdata | pix_bit_q;
    end else begin
      ram_wdata = ram_rdata & ~pix_bit_q;
    end
  end

  pfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pend_d    = pend_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    col_d     = col_q;
    wfirst_d  = wfirst_q;
    wlast_d   = wlast_q;
    active_d  = active_q;
    pend_clr  = pend_q & ~(8'd1 << cur_q);
    emit_byte = pfr_pkg::BYTE_ZERO;
    emit_data = 1'b0;
    emit_last = 1'b0;
    if (cmd_i.accept && op == pfr_pkg::OP_START) begin
      pend_d   = page_select_i & PAGE_MASK;
      wfirst_d = first_column_i;
      wlast_d  = last_column_i;
      col_d    = first_column_i;
      phase_d  = pfr_pkg::PH_CMD_PAGE;
      cur_d    = pfr_pkg::lowest_page(page_select_i & PAGE_MASK);
      active_d = (page_select_i & PAGE_MASK) != 8'd0;
    end else if (cmd_i.emit) begin
      case (phase_q)
        pfr_pkg::PH_CMD_PAGE: begin
          emit_byte = pfr_pkg::CMD_PAGE_BASE + {5'd0, cur_q};
          phase_d   = pfr_pkg::PH_CMD_COL_LO;
        end
        pfr_pkg::PH_CMD_COL_LO: begin
          emit_byte = {1'b0, wfirst_q} & pfr_pkg::CMD_COL_LO_MASK;
          phase_d   = pfr_pkg::PH_CMD_COL_HI;
        end
        pfr_pkg::PH_CMD_COL_HI: begin
          emit_byte = pfr_pkg::CMD_COL_HI_BASE + {5'd0, wfirst_q[6:4]};
          if (wlast_q < wfirst_q) begin
            pend_d  = pend_clr;
            phase_d = pfr_pkg::PH_CMD_PAGE;
            if (pend_clr == 8'd0) begin
              active_d  = 1'b0;
              emit_last = 1'b1;
            end else begin
              cur_d = pfr_pkg::lowest_page(pend_clr);
            end
          end else begin
            col_d   = wfirst_q;
            phase_d = pfr_pkg::PH_DATA;
          end
        end
        default: begin
          emit_data = 1'b1;
          emit_byte = col_ok ? ram_rdata : pfr_pkg::BYTE_ZERO;
          if (col_q >= wlast_q) begin
            pend_d  = pend_clr;
            phase_d = pfr_pkg::PH_CMD_PAGE;
            if (pend_clr == 8'd0) begin
              active_d  = 1'b0;
              emit_last = 1'b1;
            end else begin
              cur_d = pfr_pkg::lowest_page(pend_clr);
            end
          end else begin
            col_d = col_q + 7'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      pend_q      <= '0;
      cur_q       <= '0;
      phase_q     <= pfr_pkg::PH_CMD_PAGE;
      col_q       <= '0;
      wfirst_q    <= '0;
      wlast_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_we) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      pend_q   <= pend_d;
      cur_q    <= cur_d;
      phase_q  <= phase_d;
      col_q    <= col_d;
      wfirst_q <= wfirst_d;
      wlast_q  <= wlast_d;
      active_q <= active_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_addr_q <= pix_addr;
      pix_bit_q  <= pfr_pkg::PIXEL_BIT_TOP >> pixel_y_i[2:0];
      pix_set_q  <= op == pfr_pkg::OP_SET;
    end
    if (cmd_i.emit) begin
      out_byte_q   <= emit_byte;
      is_data_q    <= emit_data;
      final_byte_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_data_o    = is_data_q;
  assign final_byte_o = final_byte_q;

endmodule
`default_nettype wire

FILE: hw/rtl/page_framebuffer_refresh.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer refresh
// Page-organized monochrome framebuffer with a panel refresh byte sequencer.
// ----------------------------------------------------------------------------
// In-range pixel set and clear beats read the store in IDLE and write it back in
// PIX_WR; other pixel beats, refresh start beats and idle tick beats leave it idle.
// A tick beat that emits a byte passes TICK_RD and TICK_OUT to the output register,
// and waits in TICK_RD while the previous byte there is not yet accepted.
// After reset a clearing pass writes the store, one byte per cycle, through all
// COLUMNS*PAGES bytes, and no input beat is accepted until it ends.
module page_framebuffer_refresh #(
  parameter int unsigned COLUMNS = pfr_pkg::COLUMNS_DEFAULT,
  parameter int unsigned PAGES   = pfr_pkg::PAGES_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfr_in_if.sink    in_i,
  pfr_out_if.source out_o
);

  pfr_pkg::ctrl_cmd_t    cmd;
  pfr_pkg::ctrl_status_t status;

  pfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfr_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (in_i.operation),
    .pixel_x_i      (in_i.pixel_x),
    .pixel_y_i      (in_i.pixel_y),
    .page_select_i  (in_i.page_select),
    .first_column_i (in_i.first_column),
    .last_column_i  (in_i.last_column),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_byte_o     (out_o.out_byte),
    .is_data_o      (out_o.is_data),
    .final_byte_o   (out_o.final_byte)
  );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer refresh testbench
// Sends pixel, refresh start and tick beats into the block with random
// idle bursts on both channels. A local model of the store and the refresh
// sequencer predicts every panel byte, and a monitor checks each output beat
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned COLUMNS    = pfr_pkg::COLUMNS_DEFAULT;
  localparam int unsigned PAGES      = pfr_pkg::PAGES_DEFAULT;
  localparam int unsigned NUM_OPS    = 1750;
  localparam int unsigned QUIET_TAIL = 200;
  localparam int unsigned STALL_MAX  = 5000;
  localparam int unsigned DRAIN_WAIT = 20;

  typedef struct {
    pfr_pkg::op_e operation;
    logic [7:0]   x;
    logic [7:0]   y;
    logic [7:0]   pages;
    logic [6:0]   first;
    logic [6:0]   last;
    bit           hold;
  } fb_op_t;

  typedef struct {
    logic [7:0] value;
    logic       is_data;
    logic       final_byte;
  } panel_byte_t;

  logic clk_i;
  logic rst_ni;

  pfr_in_if  in_if ();
  pfr_out_if out_if ();

  page_framebuffer_refresh dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  fb_op_t      op_q[$];
  panel_byte_t panel_q[$];

  logic [7:0]      frame_mem [COLUMNS*PAGES];
  logic [7:0]      pend_pages;
  logic [2:0]      cur_page;
  pfr_pkg::phase_e seq_phase;
  logic [6:0]      col_next;
  logic [6:0]      win_first;
  logic [6:0]      win_last;
  logic            refresh_on;

  bit          hold_next;
  bit          in_acc;
  bit          quiet;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned stall_cnt;
  int unsigned err_cnt;
  int unsigned n_pixel;
  int unsigned n_start;
  int unsigned n_tick;
  int unsigned n_bytes;
  int unsigned n_data;
  int unsigned n_seq_end;
  fb_op_t      drv_op;

  always #5 clk_i = ~clk_i;

  function automatic logic [2:0] first_set_page(input logic [7:0] mask);
    for (int p = 0; p < 8; p++) begin
      if (mask[p]) return 3'(p);
    end
    return 3'd0;
  endfunction

  task automatic retire_page(output logic seq_done);
    pend_pages = pend_pages & ~(8'h01 << cur_page);
    seq_phase  = pfr_pkg::PH_CMD_PAGE;
    if (pend_pages == 8'h00) begin
      refresh_on = 1'b0;
      seq_done   = 1'b1;
    end else begin
      cur_page = first_set_page(pend_pages);
      seq_done = 1'b0;
    end
  endtask

  task automatic frame_apply(input fb_op_t b);
    logic [2:0]  pg;
    logic [7:0]  bitm;
    int unsigned idx;
    panel_byte_t pb;
    case (b.operation)
      pfr_pkg::OP_SET, pfr_pkg::OP_CLEAR: begin
        if (b.x < COLUMNS && b.y < 8 * PAGES) begin
          pg   = 3'(PAGES - 1 - b.y / 8);
          bitm = pfr_pkg::PIXEL_BIT_TOP >> b.y[2:0];
          idx  = b.x * PAGES + pg;
          if (b.operation == pfr_pkg::OP_SET) frame_mem[idx] = frame_mem[idx] | bitm;
          else frame_mem[idx] = frame_mem[idx] & ~bitm;
        end
      end
      pfr_pkg::OP_START: begin
        pend_pages = b.pages & 8'((1 << PAGES) - 1);
        win_first  = b.first;
        win_last   = b.last;
        col_next   = b.first;
        seq_phase  = pfr_pkg::PH_CMD_PAGE;
        cur_page   = first_set_page(pend_pages);
        refresh_on = (pend_pages != 8'h00);
      end
      default: begin
        if (refresh_on) begin
          pb.is_data    = 1'b0;
          pb.final_byte = 1'b0;
          case (seq_phase)
            pfr_pkg::PH_CMD_PAGE: begin
              pb.value  = pfr_pkg::CMD_PAGE_BASE + {5'd0, cur_page};
              seq_phase = pfr_pkg::PH_CMD_COL_LO;
            end
            pfr_pkg::PH_CMD_COL_LO: begin
              pb.value  = {1'b0, win_first} & pfr_pkg::CMD_COL_LO_MASK;
              seq_phase = pfr_pkg::PH_CMD_COL_HI;
            end
            pfr_pkg::PH_CMD_COL_HI: begin
              pb.value = pfr_pkg::CMD_COL_HI_BASE + {5'd0, win_first[6:4]};
              if (win_last < win_first) begin
                retire_page(pb.final_byte);
              end else begin
                col_next  = win_first;
                seq_phase = pfr_pkg::PH_DATA;
              end
            end
            default: begin
              pb.is_data = 1'b1;
              if (col_next < COLUMNS) pb.value = frame_mem[col_next * PAGES + cur_page];
              else pb.value = pfr_pkg::BYTE_ZERO;
              if (col_next >= win_last) retire_page(pb.final_byte);
              else col_next = col_next + 7'd1;
            end
          endcase
          panel_q.push_back(pb);
        end
      end
    endcase
  endtask

  task automatic push_op(input pfr_pkg::op_e op, input int unsigned x, input int unsigned y,
                         input int unsigned pages, input int unsigned first,
                         input int unsigned last);
    fb_op_t b;
    b.operation = op;
    b.x         = 8'(x);
    b.y         = 8'(y);
    b.pages     = 8'(pages);
    b.first     = 7'(first);
    b.last      = 7'(last);
    b.hold      = hold_next;
    hold_next   = 1'b0;
    op_q.push_back(b);
  endtask

  task automatic push_tick();
    push_op(pfr_pkg::OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  task automatic push_pixel(input int unsigned lo, input int unsigned hi);
    int unsigned x;
    int unsigned y;
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
    end else begin
      x = $urandom_range(lo, hi);
      y = $urandom_range(0, 63);
    end
    push_op(($urandom_range(0, 2) == 0) ? pfr_pkg::OP_CLEAR : pfr_pkg::OP_SET, x, y,
            $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  // One refresh with random pixel traffic around it; some end early when
  // the next start cuts them off.
  task automatic gen_refresh();
    int unsigned mask;
    int unsigned first;
    int unsigned last;
    int unsigned hi;
    int unsigned need;
    mask = $urandom_range(1, 255);
    if ($urandom_range(0, 15) == 0) mask = 0;
    if ($urandom_range(0, 39) == 0) begin
      mask  = 1 << $urandom_range(0, 7);
      first = 0;
      last  = 127;
    end else begin
      first = $urandom_range(0, 127);
      if (first > 0 && $urandom_range(0, 7) == 0) last = $urandom_range(0, first - 1);
      else last = (first + $urandom_range(0, 6) > 127) ? 127 : first + $urandom_range(0, 6);
    end
    hi = (last >= first) ? last : first;
    repeat ($urandom_range(0, 4)) push_pixel(first, hi);
    push_op(pfr_pkg::OP_START, $urandom_range(0, 255), $urandom_range(0, 255), mask, first,
            last);
    need = $countones(8'(mask)) * (3 + ((last >= first) ? last - first + 1 : 0));
    if ($urandom_range(0, 5) == 0) need = $urandom_range(0, need);
    else need = need + $urandom_range(0, 2);
    for (int unsigned i = 0; i < need; i++) begin
      if ($urandom_range(0, 4) == 0) push_pixel(first, hi);
      push_tick();
    end
  endtask

  task automatic check_byte(input panel_byte_t got);
    panel_byte_t exp_b;
    if (panel_q.size() == 0) begin
      $error("unexpected panel byte %h (is_data %b, final_byte %b)",
             got.value, got.is_data, got.final_byte);
      err_cnt++;
    end else begin
      exp_b = panel_q.pop_front();
      n_bytes++;
      if (got.is_data) n_data++;
      if (got.final_byte) n_seq_end++;
      if (got.value !== exp_b.value) begin
        $error("out_byte: expected %h, actual %h", exp_b.value, got.value);
        err_cnt++;
      end
      if (got.is_data !== exp_b.is_data) begin
        $error("is_data: expected %b, actual %b", exp_b.is_data, got.is_data);
        err_cnt++;
      end
      if (got.final_byte !== exp_b.final_byte) begin
        $error("final_byte: expected %b, actual %b", exp_b.final_byte, got.final_byte);
        err_cnt++;
      end
    end
  endtask

  // Input and output monitor.
  always @(posedge clk_i) begin
    fb_op_t      b;
    panel_byte_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        b.operation = pfr_pkg::op_e'(in_if.operation);
        b.x         = in_if.pixel_x;
        b.y         = in_if.pixel_y;
        b.pages     = in_if.page_select;
        b.first     = in_if.first_column;
        b.last      = in_if.last_column;
        b.hold      = 1'b0;
        case (b.operation)
          pfr_pkg::OP_START: n_start++;
          pfr_pkg::OP_TICK:  n_tick++;
          default:           n_pixel++;
        endcase
        frame_apply(b);
      end
      if (out_if.valid && out_if.ready) begin
        got.value      = out_if.out_byte;
        got.is_data    = out_if.is_data;
        got.final_byte = out_if.final_byte;
        check_byte(got);
      end
    end
    in_acc <= in_if.valid && in_if.ready;
  end

  // Input driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      quiet <= (op_q.size() < QUIET_TAIL);
      if (!in_if.valid || in_acc) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_if.valid <= 1'b0;
        end else if (op_q.size() != 0 && !(op_q[0].hold && panel_q.size() != 0)) begin
          drv_op             = op_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.operation    <= drv_op.operation;
          in_if.pixel_x      <= drv_op.x;
          in_if.pixel_y      <= drv_op.y;
          in_if.page_select  <= drv_op.pages;
          in_if.first_column <= drv_op.first;
          in_if.last_column  <= drv_op.last;
          if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 7);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output sink with random back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (quiet) begin
        out_if.ready <= 1'b1;
        out_gap      <= 0;
      end else if (out_gap != 0) begin
        out_if.ready <= 1'b0;
        out_gap      <= out_gap - 1;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("page_framebuffer_refresh test failed");
        $finish;
      end
    end
  end

  initial begin
    bit held_mid;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.operation    = pfr_pkg::OP_SET;
    in_if.pixel_x      = 8'd0;
    in_if.pixel_y      = 8'd0;
    in_if.page_select  = 8'd0;
    in_if.first_column = 7'd0;
    in_if.last_column  = 7'd0;
    out_if.ready       = 1'b1;
    for (int i = 0; i < COLUMNS * PAGES; i++) frame_mem[i] = 8'h00;
    pend_pages = 8'h00;
    cur_page   = 3'd0;
    seq_phase  = pfr_pkg::PH_CMD_PAGE;
    col_next   = 7'd0;
    win_first  = 7'd0;
    win_last   = 7'd0;
    refresh_on = 1'b0;
    held_mid   = 1'b0;

    // Corner pixels, pixels just outside the panel, idle ticks, an empty
    // mask, single columns at both ends, an empty window and a restart.
    push_op(pfr_pkg::OP_SET, 0, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_SET, 127, 63, 0, 0, 0);
    push_op(pfr_pkg::OP_SET, 128, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_SET, 0, 64, 0, 0, 0);
    push_op(pfr_pkg::OP_CLEAR, 255, 255, 255, 127, 127);
    push_op(pfr_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_START, 0, 0, 8'h00, 0, 0);
    push_op(pfr_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_START, 0, 0, 8'h80, 0, 0);
    repeat (4) push_op(pfr_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_START, 0, 0, 8'h01, 127, 127);
    repeat (3) push_op(pfr_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_CLEAR, 127, 63, 0, 0, 0);
    push_op(pfr_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_START, 0, 0, 8'h10, 31, 10);
    repeat (3) push_op(pfr_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_op(pfr_pkg::OP_START, 255, 255, 8'hFF, 0, 127);
    repeat (2) push_op(pfr_pkg::OP_TICK, 255, 255, 255, 127, 127);

    hold_next = 1'b1;
    while (op_q.size() < NUM_OPS) begin
      if (!held_mid && op_q.size() > NUM_OPS / 2) begin
        hold_next = 1'b1;
        held_mid  = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          push_op(pfr_pkg::op_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 127), $urandom_range(0, 127));
        end
      end else begin
        gen_refresh();
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || in_if.valid || panel_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (panel_q.size() != 0) begin
      $error("%0d panel bytes never arrived", panel_q.size());
      err_cnt++;
    end
    $display("Sent %0d pixel, %0d refresh start and %0d tick beats.", n_pixel, n_start, n_tick);
    $display("Checked %0d panel bytes, %0d of them data, over %0d finished refreshes.",
             n_bytes, n_data, n_seq_end);
    if (err_cnt == 0) begin
      $display("page_framebuffer_refresh test passed");
    end else begin
      $display("page_framebuffer_refresh test failed");
    end
    $finish;
  end

endmodule
